// ===== design/vrs_pkg.sv =====
// ----------------------------------------------------------------------------
// vrs_pkg
// shared types, codes and defaults of the vibration rhythm sequencer
// ----------------------------------------------------------------------------
package vrs_pkg;

    localparam int NUM_RHYTHMS_DEF    = 8;
    localparam int NUM_MAGNITUDES_DEF = 8;
    localparam int PATTERN_BITS_DEF   = 64;
    localparam int DURATION_MAX_DEF   = 255;

    localparam int OP_W        = 3;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 40;
    localparam int MAG_W       = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_PLAY      = 3'd1,
        OP_LOAD_BYTE = 3'd2,
        OP_LOAD_LEN  = 3'd3,
        OP_LOAD_MAG  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_RHYTHM_UNDEF = 2'd1,
        STAT_MAG_UNDEF    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_EXEC
    } seq_state_t;

    // lowest field last
    typedef struct packed {
        logic [15:0] pwm_duty;
        logic [15:0] pwm_period;
        logic [6:0]  rhythm_length;
        logic [7:0]  pattern_byte;
        logic [2:0]  byte_index;
        logic [7:0]  duration;
        logic [2:0]  magnitude_index;
        logic [2:0]  rhythm_index;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] pwm_duty_out;
        logic [15:0] pwm_period_out;
        logic        pwm_reload;
        logic        motor_on;
    } result_t;

    typedef struct packed {
        logic [15:0] duty;
        logic [15:0] period;
    } mag_t;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ===== design/vrs_ram.sv =====
// ----------------------------------------------------------------------------
// vrs_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vrs_ram #(
    parameter int WIDTH = vrs_pkg::MAG_W,
    parameter int DEPTH = vrs_pkg::NUM_MAGNITUDES_DEF,
    parameter int AW    = vrs_pkg::idx_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/vrs_player.sv =====
// ----------------------------------------------------------------------------
// vrs_player
// playback state, rhythm length table and execution of one item
// ----------------------------------------------------------------------------
module vrs_player #(
    parameter int NUM_RHYTHMS    = vrs_pkg::NUM_RHYTHMS_DEF,
    parameter int NUM_MAGNITUDES = vrs_pkg::NUM_MAGNITUDES_DEF,
    parameter int PATTERN_BITS   = vrs_pkg::PATTERN_BITS_DEF,
    parameter int DURATION_MAX   = vrs_pkg::DURATION_MAX_DEF,
    parameter int PA_W           = vrs_pkg::idx_w(NUM_RHYTHMS * ((PATTERN_BITS + 7) / 8)),
    parameter int MI_W           = vrs_pkg::idx_w(NUM_MAGNITUDES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 exec,
    input  vrs_pkg::op_t         op,
    input  vrs_pkg::item_t       item,
    input  logic [7:0]           pat_rdata,
    input  vrs_pkg::mag_t        mag_rdata,
    output vrs_pkg::result_t     result,
    output logic [PA_W-1:0]      pat_raddr,
    output logic                 pat_we,
    output logic [PA_W-1:0]      pat_waddr,
    output logic [7:0]           pat_wdata,
    output logic                 mag_we,
    output logic [MI_W-1:0]      mag_waddr,
    output vrs_pkg::mag_t        mag_wdata
);

    localparam int BPR   = (PATTERN_BITS + 7) / 8;
    localparam int RI_W  = vrs_pkg::idx_w(NUM_RHYTHMS);
    localparam int LEN_W = $clog2(PATTERN_BITS + 1);

    logic [LEN_W-1:0] len_reg [NUM_RHYTHMS];
    logic [2:0]       active_reg, active_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [7:0]       cycles_reg, cycles_next;
    logic             motor_reg, motor_next;

    logic             ri_ok, mi_ok, bi_ok, act_ok;
    logic [LEN_W-1:0] play_len, act_len, pos_inc, len_sat;
    logic             pat_bit;
    logic             len_we;
    vrs_pkg::mag_t    mag_sel;

    always_comb
    begin
        ri_ok    = 32'(item.rhythm_index) < NUM_RHYTHMS;
        mi_ok    = 32'(item.magnitude_index) < NUM_MAGNITUDES;
        bi_ok    = 32'(item.byte_index) < BPR;
        act_ok   = 32'(active_reg) < NUM_RHYTHMS;
        play_len = ri_ok ? len_reg[RI_W'(item.rhythm_index)] : '0;
        act_len  = act_ok ? len_reg[RI_W'(active_reg)] : '0;
        pos_inc  = pos_reg + 1'b1;
        pat_bit  = pat_rdata[pos_reg[2:0] ^ 3'b111];
        len_sat  = (32'(item.rhythm_length) > PATTERN_BITS) ?
                   LEN_W'(PATTERN_BITS) : LEN_W'(item.rhythm_length);
        mag_sel  = mi_ok ? mag_rdata : '0;
    end

    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        cycles_next = cycles_reg;
        motor_next  = motor_reg;
        len_we      = 1'b0;
        pat_we      = 1'b0;
        mag_we      = 1'b0;
        result      = '0;
        unique case (op)
            vrs_pkg::OP_TICK:
            begin
                if (cycles_reg == 8'd0)
                begin
                    motor_next = 1'b0;
                end
                else
                begin
                    motor_next = pat_bit;
                    if (pos_inc >= act_len)
                    begin
                        pos_next = '0;
                        if (32'(cycles_reg) < DURATION_MAX)
                        begin
                            cycles_next = cycles_reg - 8'd1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
            end
            vrs_pkg::OP_PLAY:
            begin
                if (item.duration != 8'd0 && play_len == '0)
                begin
                    result.status = vrs_pkg::STAT_RHYTHM_UNDEF;
                end
                else if (item.duration != 8'd0 && (!mi_ok || mag_rdata.period == 16'd0))
                begin
                    result.status = vrs_pkg::STAT_MAG_UNDEF;
                end
                else
                begin
                    motor_next            = 1'b0;
                    result.pwm_reload     = 1'b1;
                    result.pwm_period_out = mag_sel.period;
                    result.pwm_duty_out   = mag_sel.duty;
                    active_next           = item.rhythm_index;
                    pos_next              = '0;
                    cycles_next           = item.duration;
                end
            end
            vrs_pkg::OP_LOAD_BYTE:
            begin
                pat_we = exec && ri_ok && bi_ok;
            end
            vrs_pkg::OP_LOAD_LEN:
            begin
                len_we = exec && ri_ok;
            end
            vrs_pkg::OP_LOAD_MAG:
            begin
                mag_we = exec && mi_ok;
            end
            default:
            begin
            end
        endcase
        result.motor_on = motor_next;
    end

    assign pat_raddr = PA_W'(32'(active_reg) * BPR + 32'(pos_reg >> 3));
    assign pat_waddr = PA_W'(32'(item.rhythm_index) * BPR + 32'(item.byte_index));
    assign pat_wdata = item.pattern_byte;
    assign mag_waddr = MI_W'(item.magnitude_index);
    assign mag_wdata = '{duty: item.pwm_duty, period: item.pwm_period};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            pos_reg    <= '0;
            cycles_reg <= '0;
            motor_reg  <= 1'b0;
            for (int i = 0; i < NUM_RHYTHMS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (exec)
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            cycles_reg <= cycles_next;
            motor_reg  <= motor_next;
            if (len_we)
            begin
                len_reg[RI_W'(item.rhythm_index)] <= len_sat;
            end
        end
    end

endmodule

// ===== design/vibration_rhythm_sequencer.sv =====
// ----------------------------------------------------------------------------
// vibration_rhythm_sequencer
// plays stored on/off rhythm patterns with selectable pwm magnitude
// ----------------------------------------------------------------------------
// usage
//   s_* carries one item per transfer: s_tuser is the operation (tick, play,
//   load pattern byte, load rhythm length, load magnitude), s_tdata its
//   operands. every item gives exactly one result on m_*: motor enable,
//   pwm reload flag with period and duty, and the play status.
//   the accept edge reads the pattern and magnitude rams into their
//   registered read ports; the item then executes in the exec state once
//   the output register is free, writing back and loading that register.
//   a new item is accepted only after the last one has executed, a limit
//   set by the read-then-execute sequence around the two rams. m_tvalid
//   rises with the output register load, at the executing edge.
//   after reset a clearing pass zeroes both rams, one entry per cycle, over
//   max(NUM_RHYTHMS * ceil(PATTERN_BITS / 8), NUM_MAGNITUDES) entries
//   (64 by default); s_tready stays low meanwhile. the length table and
//   playback state clear at once.
//   when the receiver stalls, the result holds in the output register and
//   one further item may be accepted; its execution waits until the
//   register is free.
// ----------------------------------------------------------------------------
module vibration_rhythm_sequencer #(
    parameter int NUM_RHYTHMS    = vrs_pkg::NUM_RHYTHMS_DEF,
    parameter int NUM_MAGNITUDES = vrs_pkg::NUM_MAGNITUDES_DEF,
    parameter int PATTERN_BITS   = vrs_pkg::PATTERN_BITS_DEF,
    parameter int DURATION_MAX   = vrs_pkg::DURATION_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rhythm_index, magnitude_index, duration, byte_index, pattern_byte,
    // rhythm_length, pwm_period, pwm_duty
    input  logic [vrs_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [vrs_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // motor_on, pwm_reload, pwm_period_out, pwm_duty_out, status, zero fill
    output logic [vrs_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int BPR       = (PATTERN_BITS + 7) / 8;
    localparam int PAT_DEPTH = NUM_RHYTHMS * BPR;
    localparam int PA_W      = vrs_pkg::idx_w(PAT_DEPTH);
    localparam int MI_W      = vrs_pkg::idx_w(NUM_MAGNITUDES);
    localparam int CLR_DEPTH = (PAT_DEPTH > NUM_MAGNITUDES) ? PAT_DEPTH : NUM_MAGNITUDES;
    localparam int CLR_W     = vrs_pkg::idx_w(CLR_DEPTH);
    localparam int RES_W     = $bits(vrs_pkg::result_t);

    vrs_pkg::seq_state_t state_reg, state_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    vrs_pkg::item_t      item_reg, s_item;
    vrs_pkg::op_t        op_reg;
    logic                m_valid_reg, m_valid_next;
    vrs_pkg::result_t    m_data_reg;

    logic                s_fire, out_free, exec, clearing, clr_last;
    vrs_pkg::result_t    result;

    logic [PA_W-1:0]     pat_raddr, pl_pat_waddr, pat_waddr;
    logic                pl_pat_we, pat_we;
    logic [7:0]          pl_pat_wdata, pat_wdata, pat_rdata;
    logic [MI_W-1:0]     mag_raddr, pl_mag_waddr, mag_waddr;
    logic                pl_mag_we, mag_we;
    vrs_pkg::mag_t       pl_mag_wdata, mag_wdata, mag_rdata;

    assign s_item   = vrs_pkg::item_t'(s_tdata);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign clr_last = 32'(clr_cnt_reg) == CLR_DEPTH - 1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vrs_pkg::SEQ_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = vrs_pkg::SEQ_IDLE;
                end
            end
            vrs_pkg::SEQ_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = vrs_pkg::SEQ_EXEC;
                end
            end
            vrs_pkg::SEQ_EXEC:
            begin
                if (out_free)
                begin
                    state_next = vrs_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = vrs_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        exec     = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            vrs_pkg::SEQ_CLEAR:
            begin
                clearing = 1'b1;
            end
            vrs_pkg::SEQ_IDLE:
            begin
                s_tready = 1'b1;
            end
            vrs_pkg::SEQ_EXEC:
            begin
                exec = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        m_valid_next = exec ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= vrs_pkg::SEQ_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg <= s_item;
            op_reg   <= vrs_pkg::op_t'(s_tuser);
        end
        if (exec)
        begin
            m_data_reg <= result;
        end
    end

    // clearing pass takes the write ports
    always_comb
    begin
        if (clearing)
        begin
            pat_we    = 32'(clr_cnt_reg) < PAT_DEPTH;
            pat_waddr = PA_W'(clr_cnt_reg);
            pat_wdata = '0;
            mag_we    = 32'(clr_cnt_reg) < NUM_MAGNITUDES;
            mag_waddr = MI_W'(clr_cnt_reg);
            mag_wdata = '0;
        end
        else
        begin
            pat_we    = pl_pat_we;
            pat_waddr = pl_pat_waddr;
            pat_wdata = pl_pat_wdata;
            mag_we    = pl_mag_we;
            mag_waddr = pl_mag_waddr;
            mag_wdata = pl_mag_wdata;
        end
        mag_raddr = (32'(s_item.magnitude_index) < NUM_MAGNITUDES) ?
                    MI_W'(s_item.magnitude_index) : '0;
    end

    vrs_ram #(
        .WIDTH (8),
        .DEPTH (PAT_DEPTH),
        .AW    (PA_W)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .re    (s_fire),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    vrs_ram #(
        .WIDTH (vrs_pkg::MAG_W),
        .DEPTH (NUM_MAGNITUDES),
        .AW    (MI_W)
    ) u_magnitude_ram (
        .clk   (clk),
        .we    (mag_we),
        .waddr (mag_waddr),
        .wdata (mag_wdata),
        .re    (s_fire),
        .raddr (mag_raddr),
        .rdata (mag_rdata)
    );

    vrs_player #(
        .NUM_RHYTHMS    (NUM_RHYTHMS),
        .NUM_MAGNITUDES (NUM_MAGNITUDES),
        .PATTERN_BITS   (PATTERN_BITS),
        .DURATION_MAX   (DURATION_MAX),
        .PA_W           (PA_W),
        .MI_W           (MI_W)
    ) u_player (
        .clk       (clk),
        .rst_n     (rst_n),
        .exec      (exec),
        .op        (op_reg),
        .item      (item_reg),
        .pat_rdata (pat_rdata),
        .mag_rdata (mag_rdata),
        .result    (result),
        .pat_raddr (pat_raddr),
        .pat_we    (pl_pat_we),
        .pat_waddr (pl_pat_waddr),
        .pat_wdata (pl_pat_wdata),
        .mag_we    (pl_mag_we),
        .mag_waddr (pl_mag_waddr),
        .mag_wdata (pl_mag_wdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(vrs_pkg::M_TDATA_W - RES_W)'(0), m_data_reg};

`ifndef SYNTH
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> state_reg == vrs_pkg::SEQ_EXEC)
        else $error("accepted item did not enter execution");

    a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vrs_pkg::SEQ_EXEC) && !out_free |=> state_reg == vrs_pkg::SEQ_EXEC)
        else $error("execution left while output register full");

    a_reload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_data_reg.pwm_reload |-> m_data_reg.status == vrs_pkg::STAT_OK)
        else $error("pwm reload with failing status");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !s_tready && !m_valid_reg)
        else $error("transfer during clearing pass");
`endif

endmodule
